@@ rtl/coap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_pkg: shared types and constants for the CoAP message parser
// Phase codes, item kinds, status codes and the word passed front to back.
// ----------------------------------------------------------------------------
package coap_pkg;

    typedef enum logic [3:0] {
        PH_H0      = 4'd0,
        PH_H1      = 4'd1,
        PH_H2      = 4'd2,
        PH_H3      = 4'd3,
        PH_TOKEN   = 4'd4,
        PH_OPT     = 4'd5,
        PH_DX1     = 4'd6,
        PH_DX2A    = 4'd7,
        PH_DX2B    = 4'd8,
        PH_LX1     = 4'd9,
        PH_LX2A    = 4'd10,
        PH_LX2B    = 4'd11,
        PH_VALUE   = 4'd12,
        PH_PAYLOAD = 4'd13,
        PH_SKIP    = 4'd14
    } t_phase;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_TOKEN   = 3'd1;
    localparam logic [2:0] KIND_OPTHDR  = 3'd2;
    localparam logic [2:0] KIND_OPTVAL  = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_VERSION   = 3'd2;
    localparam logic [2:0] ST_TOKLONG   = 3'd3;
    localparam logic [2:0] ST_TOKTRUNC  = 3'd4;
    localparam logic [2:0] ST_BADOPT    = 3'd5;

    localparam logic       CFG_MAX_BYTES = 1'b0;
    localparam logic       CFG_MAX_OPTS  = 1'b1;

    localparam logic [15:0] EXT1_ADD = 16'd13;
    localparam logic [15:0] EXT2_ADD = 16'd269;
    localparam logic [7:0]  MARKER   = 8'hFF;
    localparam logic [3:0]  NIB_EXT1 = 4'd13;
    localparam logic [3:0]  NIB_EXT2 = 4'd14;
    localparam logic [3:0]  NIB_BAD  = 4'd15;
    localparam logic [3:0]  MAX_TKL  = 4'd8;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int unsigned RESQ_DEPTH = 4;
    localparam int unsigned RESQ_AW    = $clog2(RESQ_DEPTH);

    // front word: one classified input byte
    typedef struct packed {
        logic       take;
        logic [7:0] data;
        logic       last;
    } t_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value_byte;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [1:0]  message_type;
        logic [7:0]  message_code;
        logic [15:0] message_id;
        logic [3:0]  token_length;
        logic [2:0]  status;
        logic        last_item;
    } t_item;

endpackage

@@ rtl/coap_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_front: byte intake
// Counts kept bytes against the size limit and queues classified words.
// ----------------------------------------------------------------------------
module coap_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic [15:0]          i_max_bytes,
    input  logic                 i_deq,
    output logic                 o_full,
    output logic                 o_avail,
    output coap_pkg::t_word      o_word
);
    import coap_pkg::*;

    logic [15:0]         r_count;
    t_word               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp, r_rp;
    logic [FIFO_AW:0]    r_fill;
    logic                acc;

    assign o_full  = (r_fill == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_avail = (r_fill != '0);
    assign o_word  = r_mem[r_rp];
    assign acc     = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_fill  <= '0;
        end else begin
            if (acc) begin
                r_mem[r_wp].take <= (r_count < i_max_bytes);
                r_mem[r_wp].data <= i_data_byte;
                r_mem[r_wp].last <= i_last_byte;
                r_wp <= r_wp + 1'b1;
                if (i_last_byte) begin
                    r_count <= '0;
                end else if (r_count < i_max_bytes) begin
                    r_count <= r_count + 16'd1;
                end
            end
            if (i_deq) begin
                r_rp <= r_rp + 1'b1;
            end
            r_fill <= r_fill + (FIFO_AW+1)'(acc) - (FIFO_AW+1)'(i_deq);
        end
    end
endmodule

@@ rtl/coap_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_back: parse engine and result queue
// Runs the phase machine on each word and queues up to two result items.
// ----------------------------------------------------------------------------
module coap_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_avail,
    input  coap_pkg::t_word      i_word,
    input  logic [7:0]           i_max_opts,
    input  logic                 i_pop,
    output logic                 o_deq,
    output logic                 o_empty,
    output coap_pkg::t_item      o_item
);
    import coap_pkg::*;

    t_phase      r_phase, n_phase;
    logic [23:0] r_hdr, n_hdr;
    logic [3:0]  r_tok, n_tok;
    logic [15:0] r_num, n_num;
    logic [15:0] r_dlt, n_dlt;
    logic [15:0] r_len, n_len;
    logic [15:0] r_vleft, n_vleft;
    logic [7:0]  r_ocnt, n_ocnt;
    logic [2:0]  r_err, n_err;

    t_item       r_q [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_wp, r_rp;
    logic [RESQ_AW:0]   r_fill;

    t_item       it_a, it_b;
    logic        va, vb, go;
    logic [7:0]  b;
    logic [3:0]  dn, ln;
    logic [15:0] l_len, s_num;
    logic        fin;
    logic [2:0]  st;
    logic [RESQ_AW:0] nput;
    logic        deq_out;

    assign go    = i_avail && (r_fill <= (RESQ_AW+1)'(RESQ_DEPTH - 2));
    assign o_deq = go;
    assign b     = i_word.data;
    assign dn    = b[7:4];
    assign ln    = b[3:0];

    always_comb begin
        n_phase = r_phase; n_hdr = r_hdr; n_tok = r_tok; n_num = r_num;
        n_dlt = r_dlt; n_len = r_len; n_vleft = r_vleft; n_ocnt = r_ocnt;
        n_err = r_err;
        it_a = '0; va = 1'b0; it_b = '0; vb = 1'b0;
        fin = 1'b0; l_len = r_len; s_num = r_num; st = ST_OK;
        if (i_word.take) begin
            case (r_phase)
                PH_H0, PH_H1, PH_H2: begin
                    n_hdr = {r_hdr[15:0], b};
                    n_phase = t_phase'(r_phase + 4'd1);
                end
                PH_H3: begin
                    if (r_hdr[23:22] != 2'd1) begin
                        n_err = ST_VERSION; n_phase = PH_SKIP;
                    end else if (r_hdr[19:16] > MAX_TKL) begin
                        n_err = ST_TOKLONG; n_phase = PH_SKIP;
                    end else begin
                        va = 1'b1;
                        it_a.kind = KIND_HEADER;
                        it_a.message_type = r_hdr[21:20];
                        it_a.message_code = r_hdr[15:8];
                        it_a.message_id = {r_hdr[7:0], b};
                        it_a.token_length = r_hdr[19:16];
                        n_tok = r_hdr[19:16];
                        n_phase = (r_hdr[19:16] != 4'd0) ? PH_TOKEN : PH_OPT;
                    end
                end
                PH_TOKEN: begin
                    va = 1'b1; it_a.kind = KIND_TOKEN; it_a.value_byte = b;
                    n_tok = r_tok - 4'd1;
                    if (r_tok == 4'd1) n_phase = PH_OPT;
                end
                PH_OPT: begin
                    if (b == MARKER) begin
                        n_phase = PH_PAYLOAD;
                    end else if (r_ocnt >= i_max_opts) begin
                        n_phase = PH_SKIP;
                    end else if (dn == NIB_BAD || ln == NIB_BAD) begin
                        n_err = ST_BADOPT; n_phase = PH_SKIP;
                    end else begin
                        n_dlt = {12'd0, dn}; n_len = {12'd0, ln};
                        if (dn == NIB_EXT1) n_phase = PH_DX1;
                        else if (dn == NIB_EXT2) n_phase = PH_DX2A;
                        else if (ln == NIB_EXT1) n_phase = PH_LX1;
                        else if (ln == NIB_EXT2) n_phase = PH_LX2A;
                        else begin
                            fin = 1'b1; l_len = {12'd0, ln}; s_num = r_num + {12'd0, dn};
                        end
                    end
                end
                PH_DX1, PH_DX2B: begin
                    n_dlt = (r_phase == PH_DX1) ? ({8'd0, b} + EXT1_ADD)
                                                : ({r_dlt[15:8], b} + EXT2_ADD);
                    if (r_len[3:0] == NIB_EXT1) n_phase = PH_LX1;
                    else if (r_len[3:0] == NIB_EXT2) n_phase = PH_LX2A;
                    else begin fin = 1'b1; l_len = r_len; s_num = r_num + n_dlt; end
                end
                PH_DX2A: begin
                    n_dlt = {b, 8'd0}; n_phase = PH_DX2B;
                end
                PH_LX1: begin
                    fin = 1'b1; l_len = {8'd0, b} + EXT1_ADD; s_num = r_num + r_dlt;
                end
                PH_LX2A: begin
                    n_len = {b, 8'd0}; n_phase = PH_LX2B;
                end
                PH_LX2B: begin
                    fin = 1'b1; l_len = {r_len[15:8], b} + EXT2_ADD; s_num = r_num + r_dlt;
                end
                PH_VALUE: begin
                    va = 1'b1; it_a.kind = KIND_OPTVAL; it_a.value_byte = b;
                    it_a.option_number = r_num;
                    n_vleft = r_vleft - 16'd1;
                    if (r_vleft == 16'd1) n_phase = PH_OPT;
                end
                PH_PAYLOAD: begin
                    va = 1'b1; it_a.kind = KIND_PAYLOAD; it_a.value_byte = b;
                end
                default: begin
                end
            endcase
            if (fin) begin
                n_num = s_num; n_len = l_len; n_vleft = l_len;
                n_ocnt = r_ocnt + 8'd1;
                va = 1'b1; it_a.kind = KIND_OPTHDR;
                it_a.option_number = s_num; it_a.option_length = l_len;
                n_phase = (l_len != 16'd0) ? PH_VALUE : PH_OPT;
            end
        end
        if (n_err != ST_OK) st = n_err;
        else if (n_phase <= PH_H3) st = ST_SHORT;
        else if (n_phase == PH_TOKEN) st = ST_TOKTRUNC;
        else if (n_phase >= PH_DX1 && n_phase <= PH_VALUE) st = ST_BADOPT;
        else st = ST_OK;
        if (i_word.last) begin
            vb = 1'b1; it_b.kind = KIND_END; it_b.status = st; it_b.last_item = 1'b1;
            n_phase = PH_H0; n_hdr = '0; n_tok = '0; n_num = '0; n_dlt = '0;
            n_len = '0; n_vleft = '0; n_ocnt = '0; n_err = '0;
        end
    end

    assign o_empty = (r_fill == '0);
    assign o_item  = r_q[r_rp];
    assign deq_out = i_pop && !o_empty;
    assign nput    = go ? ((RESQ_AW+1)'(va) + (RESQ_AW+1)'(vb)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_H0; r_hdr <= '0; r_tok <= '0; r_num <= '0;
            r_dlt <= '0; r_len <= '0; r_vleft <= '0; r_ocnt <= '0; r_err <= '0;
            r_wp <= '0; r_rp <= '0; r_fill <= '0;
        end else begin
            if (go) begin
                r_phase <= n_phase; r_hdr <= n_hdr; r_tok <= n_tok; r_num <= n_num;
                r_dlt <= n_dlt; r_len <= n_len; r_vleft <= n_vleft;
                r_ocnt <= n_ocnt; r_err <= n_err;
                if (va) begin
                    r_q[r_wp] <= it_a;
                    if (vb) r_q[r_wp + 1'b1] <= it_b;
                end else if (vb) begin
                    r_q[r_wp] <= it_b;
                end
                r_wp <= r_wp + nput[RESQ_AW-1:0];
            end
            if (deq_out) r_rp <= r_rp + 1'b1;
            r_fill <= r_fill + nput - (RESQ_AW+1)'(deq_out);
        end
    end
endmodule

@@ rtl/coap_message_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_message_parser: CoAP datagram parser, one byte per word
// Throughput: one byte per cycle while the result queue has two free entries;
// a last byte that also yields an item writes two result words at once into
// the 4-entry result queue.
// Reset: synchronous active low; limits return to 256 bytes and 16 options.
// ----------------------------------------------------------------------------
module coap_message_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_item_kind,
    output logic [7:0]  o_value_byte,
    output logic [15:0] o_option_number,
    output logic [15:0] o_option_length,
    output logic [1:0]  o_message_type,
    output logic [7:0]  o_message_code,
    output logic [15:0] o_message_id,
    output logic [3:0]  o_token_length,
    output logic [2:0]  o_status,
    output logic        o_last_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import coap_pkg::*;

    logic [15:0] r_max_bytes;
    logic [7:0]  r_max_opts;
    logic        avail, deq;
    t_word       word;
    t_item       item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= 16'd256;
            r_max_opts  <= 8'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_BYTES: r_max_bytes <= i_cfg_data;
                CFG_MAX_OPTS:  r_max_opts  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    coap_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push),
        .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .i_max_bytes(r_max_bytes), .i_deq(deq), .o_full(full),
        .o_avail(avail), .o_word(word)
    );

    coap_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(avail), .i_word(word),
        .i_max_opts(r_max_opts), .i_pop(pop), .o_deq(deq),
        .o_empty(empty), .o_item(item)
    );

    assign o_item_kind     = item.kind;
    assign o_value_byte    = item.value_byte;
    assign o_option_number = item.option_number;
    assign o_option_length = item.option_length;
    assign o_message_type  = item.message_type;
    assign o_message_code  = item.message_code;
    assign o_message_id    = item.message_id;
    assign o_token_length  = item.token_length;
    assign o_status        = item.status;
    assign o_last_item     = item.last_item;

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_item_kind == KIND_END |-> o_last_item)
        else $error("end word without last flag");
    a_deq_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deq |-> avail)
        else $error("dequeue from empty front queue");
    a_tkl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_item_kind == KIND_HEADER |-> o_token_length <= MAX_TKL)
        else $error("header word with long token");
endmodule
